// ----- src/uart_register_block_with_rx_buffer_defines.svh -----
// ----------------------------------------------------------------------------
// uart register block assertion macros
// shared assertion helpers for the uart register block with receive buffer
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_BLOCK_WITH_RX_BUFFER_DEFINES_SVH
`define UART_REGISTER_BLOCK_WITH_RX_BUFFER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UARTRB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define UARTRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/uartrb_pkg.sv -----
// ----------------------------------------------------------------------------
// uartrb_pkg
// types and constants of the uart register block
// ----------------------------------------------------------------------------
package uartrb_pkg;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RECV  = 2'd2,
      OP_ACK   = 2'd3
   } uartrb_op_type;

   typedef enum logic [2:0] {
      REG_RHR = 3'd0,
      REG_IER = 3'd1,
      REG_ISR = 3'd2,
      REG_LCR = 3'd3,
      REG_MCR = 3'd4,
      REG_LSR = 3'd5,
      REG_MSR = 3'd6,
      REG_SCR = 3'd7
   } uartrb_reg_type;

   localparam int REG_ADDR_W = 12;
   localparam int BYTE_W     = 8;

   localparam logic [7:0] FCR_CLEAR_BITS = 8'h06;
   localparam int         FCR_ENABLE_BIT = 0;
   localparam int         LCR_DLAB_BIT   = 7;

   localparam logic [7:0] ISR_CAUSE_RX   = 8'h04;
   localparam logic [7:0] ISR_CAUSE_TX   = 8'h02;
   localparam logic [7:0] ISR_NO_IRQ     = 8'h01;
   localparam logic [7:0] LCR_READ_VALUE = 8'h03;
   localparam logic [7:0] MCR_READ_VALUE = 8'h00;
   localparam logic [7:0] MSR_READ_VALUE = 8'hFF;
   localparam logic [7:0] LSR_DATA_READY = 8'h01;
   localparam logic [7:0] LSR_THR_EMPTY  = 8'h20;
   localparam logic [7:0] LSR_TX_EMPTY   = 8'h40;

endpackage

// ----- src/uartrb_ram.sv -----
// ----------------------------------------------------------------------------
// uartrb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module uartrb_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 512,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/uart_register_block_with_rx_buffer.sv -----
// ----------------------------------------------------------------------------
// uart_register_block_with_rx_buffer
// 16550-style register file with a linear receive buffer held in ram
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction per bus read, bus write, received byte or
//   interrupt acknowledge, the kind given in req_tuser
//   rsp channel: exactly one transaction per request, in request order,
//   carrying read data, the transmitted byte with its flag, and the
//   interrupt line as it stands after that request
// pipeline and throughput
//   a request passes stage one and the output register before its response is
//   presented; one request per cycle while rsp_tready is high: all register and
//   index updates land in the accept cycle, the receive ram does one write or one
//   read per cycle and its registered read data feeds the output stage
// reset
//   synchronous, active high; indices, registers, interrupt state and both
//   pipeline valids clear; buffer contents are not cleared, only written
//   entries are ever read
// back-pressure
//   with rsp_tready low the output register and the stage behind it hold,
//   req_tready drops once both are full and no request is lost
// ----------------------------------------------------------------------------
`include "uart_register_block_with_rx_buffer_defines.svh"

module uart_register_block_with_rx_buffer #(
   parameter int RX_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // reg_addr[11:0], write_data[19:12], rx_byte[27:20]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // read_data[7:0], tx_byte[15:8], irq[16]
   output logic [0:0]  rsp_tuser    // tx_valid[0]
);

   import uartrb_pkg::*;

   // index wide enough to hold the depth itself, ram address for entries
   localparam int IDX_W  = $clog2(RX_DEPTH + 1);
   localparam int ADDR_W = $clog2(RX_DEPTH);
   localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(RX_DEPTH);
   localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);

   // request fields
   uartrb_op_type         req_op;
   logic [REG_ADDR_W-1:0] req_addr;
   logic [BYTE_W-1:0]     req_wdata;
   logic [BYTE_W-1:0]     req_rxbyte;
   uartrb_reg_type        req_reg;
   logic                  req_decoded;

   assign req_op      = uartrb_op_type'(req_tuser);
   assign req_addr    = req_tdata[11:0];
   assign req_wdata   = req_tdata[19:12];
   assign req_rxbyte  = req_tdata[27:20];
   assign req_reg     = uartrb_reg_type'(req_addr[2:0]);
   assign req_decoded = (req_addr[REG_ADDR_W-1:3] == '0);

   // architectural state
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [BYTE_W-1:0] ier_ff, ier_in;
   logic              fifo_en_ff, fifo_en_in;
   logic              dlab_ff, dlab_in;
   logic [BYTE_W-1:0] dll_ff, dll_in;
   logic [BYTE_W-1:0] scr_ff, scr_in;
   logic              tx_pend_ff, tx_pend_in;

   // stage one: request taken, ram read in flight
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_use_mem_ff, s1_use_mem_in;
   logic [BYTE_W-1:0] s1_rdata_ff, s1_rdata_in;
   logic              s1_txv_ff, s1_txv_in;
   logic [BYTE_W-1:0] s1_txb_ff, s1_txb_in;
   logic              s1_irq_ff, s1_irq_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_rdata_ff, out_rdata_in;
   logic              out_txv_ff, out_txv_in;
   logic [BYTE_W-1:0] out_txb_ff, out_txb_in;
   logic              out_irq_ff, out_irq_in;

   // handshake
   logic accept;
   logic s1_move;
   logic have_data;

   // ram port
   logic              ram_we;
   logic              ram_re;
   logic [BYTE_W-1:0] ram_q;

   assign s1_move    = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_move;
   assign accept     = req_tvalid & req_tready;
   assign have_data  = (wr_idx_ff > rd_idx_ff);

   // decode and state update, all in the accept cycle
   always_comb begin
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      ier_in        = ier_ff;
      fifo_en_in    = fifo_en_ff;
      dlab_in       = dlab_ff;
      dll_in        = dll_ff;
      scr_in        = scr_ff;
      tx_pend_in    = tx_pend_ff;
      s1_use_mem_in = 1'b0;
      s1_rdata_in   = '0;
      s1_txv_in     = 1'b0;
      s1_txb_in     = '0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      if (accept) begin
         case (req_op)
            OP_READ: begin
               if (req_decoded) begin
                  case (req_reg)
                     REG_RHR: begin
                        if (dlab_ff) begin
                           s1_rdata_in = dll_ff;
                        end else if (have_data) begin
                           // pop one byte, rewind both indices once drained
                           ram_re        = 1'b1;
                           s1_use_mem_in = 1'b1;
                           if ((rd_idx_ff + IDX_ONE) == wr_idx_ff) begin
                              rd_idx_in = '0;
                              wr_idx_in = '0;
                           end else begin
                              rd_idx_in = rd_idx_ff + IDX_ONE;
                           end
                        end
                     end
                     REG_IER: s1_rdata_in = ier_ff;
                     REG_ISR: begin
                        s1_rdata_in = {fifo_en_ff, fifo_en_ff, 6'b0};
                        if ((ier_ff != '0) && have_data) begin
                           s1_rdata_in = s1_rdata_in | ISR_CAUSE_RX;
                        end else if (tx_pend_ff) begin
                           s1_rdata_in = s1_rdata_in | ISR_CAUSE_TX;
                        end else begin
                           s1_rdata_in = s1_rdata_in | ISR_NO_IRQ;
                        end
                     end
                     REG_LCR: s1_rdata_in = LCR_READ_VALUE;
                     REG_MCR: s1_rdata_in = MCR_READ_VALUE;
                     REG_LSR: begin
                        s1_rdata_in = LSR_THR_EMPTY | LSR_TX_EMPTY
                                      | (have_data ? LSR_DATA_READY : 8'h00);
                     end
                     REG_MSR: s1_rdata_in = MSR_READ_VALUE;
                     REG_SCR: s1_rdata_in = scr_ff;
                     default: s1_rdata_in = '0;
                  endcase
               end
            end
            OP_WRITE: begin
               if (req_decoded) begin
                  case (req_reg)
                     REG_RHR: begin
                        if (dlab_ff) begin
                           dll_in = req_wdata;
                        end else begin
                           s1_txv_in  = 1'b1;
                           s1_txb_in  = req_wdata;
                           tx_pend_in = 1'b1;
                        end
                     end
                     REG_IER: ier_in = req_wdata;
                     REG_ISR: begin
                        // fifo control: clear bits rewind the buffer
                        if ((req_wdata & FCR_CLEAR_BITS) != '0) begin
                           wr_idx_in = '0;
                           rd_idx_in = '0;
                        end
                        fifo_en_in = req_wdata[FCR_ENABLE_BIT];
                     end
                     REG_LCR: dlab_in = req_wdata[LCR_DLAB_BIT];
                     REG_SCR: scr_in  = req_wdata;
                     default: begin
                     end
                  endcase
               end
            end
            OP_RECV: begin
               // a byte arriving at a full buffer is dropped
               if (wr_idx_ff < DEPTH_IDX) begin
                  ram_we    = 1'b1;
                  wr_idx_in = wr_idx_ff + IDX_ONE;
               end
            end
            OP_ACK: tx_pend_in = 1'b0;
            default: begin
            end
         endcase
      end

      // interrupt line as it stands after this transaction
      s1_irq_in = ((ier_in != '0) && (wr_idx_in > rd_idx_in)) || tx_pend_in;

      s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

      out_valid_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_rdata_in = s1_use_mem_ff ? ram_q : s1_rdata_ff;
      out_txv_in   = s1_txv_ff;
      out_txb_in   = s1_txb_ff;
      out_irq_in   = s1_irq_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         ier_ff       <= '0;
         fifo_en_ff   <= 1'b0;
         dlab_ff      <= 1'b0;
         dll_ff       <= '0;
         scr_ff       <= '0;
         tx_pend_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         ier_ff       <= ier_in;
         fifo_en_ff   <= fifo_en_in;
         dlab_ff      <= dlab_in;
         dll_ff       <= dll_in;
         scr_ff       <= scr_in;
         tx_pend_ff   <= tx_pend_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_use_mem_ff <= s1_use_mem_in;
         s1_rdata_ff   <= s1_rdata_in;
         s1_txv_ff     <= s1_txv_in;
         s1_txb_ff     <= s1_txb_in;
         s1_irq_ff     <= s1_irq_in;
      end
      if (s1_move) begin
         out_rdata_ff <= out_rdata_in;
         out_txv_ff   <= out_txv_in;
         out_txb_ff   <= out_txb_in;
         out_irq_ff   <= out_irq_in;
      end
   end

   // receive buffer; read data holds while the stage behind it stalls
   uartrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff[ADDR_W-1:0]),
      .wr_data (req_rxbyte),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_irq_ff, out_txb_ff, out_rdata_ff};
   assign rsp_tuser  = out_txv_ff;

   // read index never passes write index, which never passes the depth
   `UARTRB_ASSERT_NOW(a_idx_order, clock, reset, 1'b1,
      (rd_idx_ff <= wr_idx_ff) && (wr_idx_ff <= DEPTH_IDX), "index order broken")

   // an empty buffer always sits rewound at zero
   `UARTRB_ASSERT_NOW(a_empty_rewound, clock, reset, rd_idx_ff == wr_idx_ff,
      wr_idx_ff == '0, "empty buffer not rewound")

   // a transmitted byte always leaves the interrupt line raised
   `UARTRB_ASSERT_NOW(a_tx_irq, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tdata[16], "transmit without interrupt")

   // ram reads only for a taken request, and its stage is then full
   `UARTRB_ASSERT_NEXT(a_ram_read, clock, reset, ram_re,
      s1_valid_ff && s1_use_mem_ff, "ram read without stage")

endmodule

// ----- sim/tb_uart_register_block_with_rx_buffer.sv -----
// ----------------------------------------------------------------------------
// tb_uart_register_block_with_rx_buffer
// self-checking bench for the uart register block: every request transaction
// is run through a behavioural copy of the register file and receive buffer,
// and each response transaction is compared field by field, in order, with
// the oldest prediction; random idling on both channels, one long response
// stall, and a burst of received bytes
// ----------------------------------------------------------------------------
module tb_uart_register_block_with_rx_buffer;
   import uartrb_pkg::*;

   localparam int RX_DEPTH    = 512;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 400;
   localparam int RX_BURST    = 24;

   typedef struct {
      uartrb_op_type op;
      logic [11:0]   addr;
      logic [7:0]    wdata;
      logic [7:0]    rxb;
   } uart_req_type;

   typedef struct {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       irq;
   } uart_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // reg_addr[11:0], write_data[19:12], rx_byte[27:20]
   logic [1:0]  req_tuser  = '0;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // read_data[7:0], tx_byte[15:8], irq[16]
   logic [0:0]  rsp_tuser;         // tx_valid[0]

   uart_register_block_with_rx_buffer #(.RX_DEPTH(RX_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 unit period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and scoreboard storage
   uart_req_type pending_req_q[$];
   uart_rsp_type expected_rsp_q[$];
   int           errors      = 0;
   int           cycle_count = 0;
   logic         req_taken   = 1'b0;

   // idling percentages per phase, long stall requested by ticket
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_ticket  = 0;
   int stall_served  = 0;
   int hold_left     = 0;

   // shadow copy of the register file and receive buffer
   logic [7:0]  rx_copy [0:RX_DEPTH-1];
   int unsigned rx_wr   = 0;
   int unsigned rx_rd   = 0;
   logic [7:0]  ier_q   = '0;
   logic [7:0]  dll_q   = '0;
   logic [7:0]  scr_q   = '0;
   logic        fifo_en = 1'b0;
   logic        dlab    = 1'b0;
   logic        tx_pend = 1'b0;

   // apply one request to the shadow state and work out its response
   function automatic uart_rsp_type uart_regs_step(uart_req_type r);
      uart_rsp_type o;
      logic         data_held;
      o = '{default: '0};
      data_held = rx_wr > rx_rd;
      case (r.op)
         OP_READ: begin
            if (r.addr < 12'd8) begin
               case (uartrb_reg_type'(r.addr[2:0]))
                  REG_RHR: begin
                     if (dlab) begin
                        o.read_data = dll_q;
                     end else if (data_held) begin
                        o.read_data = rx_copy[rx_rd];
                        rx_rd++;
                        // buffer drained: both indices back to the start
                        if (rx_rd == rx_wr) begin
                           rx_rd = 0;
                           rx_wr = 0;
                        end
                     end
                  end
                  REG_IER: o.read_data = ier_q;
                  REG_ISR: begin
                     o.read_data = {fifo_en, fifo_en, 6'b0};
                     if (ier_q != 0 && data_held) o.read_data |= ISR_CAUSE_RX;
                     else if (tx_pend)            o.read_data |= ISR_CAUSE_TX;
                     else                         o.read_data |= ISR_NO_IRQ;
                  end
                  REG_LCR: o.read_data = LCR_READ_VALUE;
                  REG_MCR: o.read_data = MCR_READ_VALUE;
                  REG_LSR: o.read_data = LSR_THR_EMPTY | LSR_TX_EMPTY |
                                         (data_held ? LSR_DATA_READY : 8'h00);
                  REG_MSR: o.read_data = MSR_READ_VALUE;
                  REG_SCR: o.read_data = scr_q;
                  default: o.read_data = '0;
               endcase
            end
         end
         OP_WRITE: begin
            if (r.addr < 12'd8) begin
               case (uartrb_reg_type'(r.addr[2:0]))
                  REG_RHR: begin
                     if (dlab) begin
                        dll_q = r.wdata;
                     end else begin
                        o.tx_valid = 1'b1;
                        o.tx_byte  = r.wdata;
                        tx_pend    = 1'b1;
                     end
                  end
                  REG_IER: ier_q = r.wdata;
                  REG_ISR: begin
                     if ((r.wdata & FCR_CLEAR_BITS) != 0) begin
                        rx_wr = 0;
                        rx_rd = 0;
                     end
                     fifo_en = r.wdata[FCR_ENABLE_BIT];
                  end
                  REG_LCR: dlab  = r.wdata[LCR_DLAB_BIT];
                  REG_SCR: scr_q = r.wdata;
                  default: ;
               endcase
            end
         end
         OP_RECV: begin
            // full buffer drops the byte
            if (rx_wr < RX_DEPTH) begin
               rx_copy[rx_wr] = r.rxb;
               rx_wr++;
            end
         end
         OP_ACK: tx_pend = 1'b0;
         default: ;
      endcase
      o.irq = (ier_q != 0 && rx_wr > rx_rd) || tx_pend;
      return o;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   task automatic push_req(uartrb_op_type op, logic [11:0] addr, logic [7:0] wd,
                           logic [7:0] rxb);
      pending_req_q.push_back('{op: op, addr: addr, wdata: wd, rxb: rxb});
   endtask

   // mostly decoded offsets, rhr reads roughly balancing received bytes so the
   // buffer keeps draining to empty, dlab and fifo clears kept occasional
   task automatic queue_uart_traffic(int count);
      uart_req_type r;
      int           pick;
      for (int n = 0; n < count; n++) begin
         pick    = $urandom_range(0, 99);
         r.wdata = 8'($urandom_range(0, 255));
         r.rxb   = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 88) r.addr = 12'($urandom_range(0, 7));
         else                            r.addr = 12'($urandom_range(8, 4095));
         if (pick < 30) begin
            r.op = OP_RECV;
         end else if (pick < 65) begin
            r.op = OP_READ;
            if (pick < 58) r.addr = 12'(REG_RHR);
         end else if (pick < 91) begin
            r.op = OP_WRITE;
         end else begin
            r.op = OP_ACK;
         end
         if (r.op == OP_WRITE && r.addr == 12'(REG_LCR) && $urandom_range(0, 3) != 0)
            r.wdata[LCR_DLAB_BIT] = 1'b0;
         if (r.op == OP_WRITE && r.addr == 12'(REG_ISR) && $urandom_range(0, 3) != 0)
            r.wdata &= ~FCR_CLEAR_BITS;
         pending_req_q.push_back(r);
      end
   endtask

   // nothing queued, nothing on the wire, nothing outstanding
   task automatic wait_drained();
      while (pending_req_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   // request driver: next transaction offered once the current one is taken
   always @(negedge clock) begin
      uart_req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            r = pending_req_q.pop_front();
            req_tdata  <= {4'b0, r.rxb, r.wdata, r.addr};
            req_tuser  <= r.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response sink: random back-pressure, plus one long hold when asked
   always @(negedge clock) begin
      if (stall_served != stall_ticket) begin
         stall_served <= stall_ticket;
         hold_left    <= LONG_HOLD;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor: check responses first, then predict for the request taken
   always @(posedge clock) begin
      uart_rsp_type want;
      uart_req_type seen;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response transaction with nothing outstanding");
               errors++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("read_data", want.read_data, rsp_tdata[7:0]);
               check_field("tx_valid",  want.tx_valid,  rsp_tuser[0]);
               check_field("tx_byte",   want.tx_byte,   rsp_tdata[15:8]);
               check_field("irq",       want.irq,       rsp_tdata[16]);
            end
         end
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            seen.op    = uartrb_op_type'(req_tuser);
            seen.addr  = req_tdata[11:0];
            seen.wdata = req_tdata[19:12];
            seen.rxb   = req_tdata[27:20];
            expected_rsp_q.push_back(uart_regs_step(seen));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // phase one: sender idles lightly, receiver heavily
      send_idle_pct = 34;
      recv_idle_pct = 68;

      // every register straight out of reset, empty rhr read included
      for (int a = 0; a < 8; a++) push_req(OP_READ, 12'(a), 8'h00, 8'h00);
      // offsets past the decoded window
      push_req(OP_READ,  12'hFFF, 8'h00, 8'hFF);
      push_req(OP_WRITE, 12'hFF8, 8'hFF, 8'h00);
      // receive interrupt path, then drain to empty
      push_req(OP_WRITE, 12'(REG_IER), 8'hFF, 8'h00);
      push_req(OP_RECV,  12'h000, 8'h00, 8'h00);
      push_req(OP_RECV,  12'hFFF, 8'hFF, 8'hFF);
      push_req(OP_READ,  12'(REG_ISR), 8'h00, 8'h00);
      push_req(OP_ACK,   12'h000, 8'h00, 8'h00);
      push_req(OP_READ,  12'(REG_RHR), 8'h00, 8'h00);
      push_req(OP_READ,  12'(REG_RHR), 8'h00, 8'h00);
      push_req(OP_READ,  12'(REG_LSR), 8'h00, 8'h00);
      // transmit-done raised with ier clear, cleared by acknowledge
      push_req(OP_WRITE, 12'(REG_IER), 8'h00, 8'h00);
      push_req(OP_WRITE, 12'(REG_RHR), 8'hA5, 8'h00);
      push_req(OP_READ,  12'(REG_ISR), 8'h00, 8'h00);
      push_req(OP_ACK,   12'h000, 8'h00, 8'h00);
      // fifo enable with clear, divisor latch under dlab, scratch
      push_req(OP_WRITE, 12'(REG_ISR), 8'hFF, 8'h00);
      push_req(OP_WRITE, 12'(REG_LCR), 8'hFF, 8'h00);
      push_req(OP_WRITE, 12'(REG_RHR), 8'h5A, 8'h00);
      push_req(OP_READ,  12'(REG_RHR), 8'h00, 8'h00);
      push_req(OP_WRITE, 12'(REG_LCR), 8'h00, 8'h00);
      push_req(OP_WRITE, 12'(REG_SCR), 8'hFF, 8'h00);
      push_req(OP_READ,  12'(REG_SCR), 8'h00, 8'h00);
      queue_uart_traffic(130);
      wait_drained();

      // phase two: roles swapped
      send_idle_pct = 68;
      recv_idle_pct = 34;
      queue_uart_traffic(130);
      wait_drained();

      // phase three: no idling, one long response hold while requests pile up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_ticket  = stall_ticket + 1;
      queue_uart_traffic(130);
      // a burst of received bytes, a few read back, then the buffer cleared
      push_req(OP_WRITE, 12'(REG_LCR), 8'h00, 8'h00);
      push_req(OP_WRITE, 12'(REG_ISR), FCR_CLEAR_BITS, 8'h00);
      push_req(OP_WRITE, 12'(REG_IER), 8'h01, 8'h00);
      for (int n = 0; n < RX_BURST; n++)
         push_req(OP_RECV, 12'h000, 8'h00, 8'($urandom_range(0, 255)));
      for (int n = 0; n < 4; n++) push_req(OP_READ, 12'(REG_RHR), 8'h00, 8'h00);
      push_req(OP_READ,  12'(REG_LSR), 8'h00, 8'h00);
      push_req(OP_WRITE, 12'(REG_ISR), FCR_CLEAR_BITS, 8'h00);
      push_req(OP_READ,  12'(REG_RHR), 8'h00, 8'h00);
      wait_drained();

      // let any stray response show up
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
